// File: hdl/cdq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdq_pkg
// Shared types and constants of the circular deque: operation and status
// codes, the register map and the record that travels with an operation.
// ----------------------------------------------------------------------------
package cdq_pkg;

    // Operation codes carried on the op port.
    typedef enum logic [1:0] {
        OP_INS_FRONT = 2'd0,
        OP_INS_REAR  = 2'd1,
        OP_DEL_FRONT = 2'd2,
        OP_DEL_REAR  = 2'd3
    } op_t;

    // Status codes reported with every result.
    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    // Register map: word index taken from paddr[2].
    localparam logic REG_CAPACITY = 1'b0;

    // Capacity after reset.
    localparam logic [7:0] CAP_RESET = 8'd128;

    // Data width of the configuration port.
    localparam int unsigned APB_DW = 32;

    // Record of an operation that waits for the store read to finish.
    typedef struct packed {
        status_t status;
        logic    pend_front;
        logic    pend_rear;
    } stage_t;

endpackage

// File: hdl/cdq_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdq_regs
// Configuration register block. Holds the capacity register, answers reads
// and derives the index of the last slot in use from the clamped capacity.
// ----------------------------------------------------------------------------
module cdq_regs
    import cdq_pkg::*;
#(
    parameter int DEPTH = 128
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [2:0]                paddr,
    input  logic [APB_DW-1:0]         pwdata,
    output logic [APB_DW-1:0]         prdata,
    output logic                      pready,
    output logic [$clog2(DEPTH)-1:0]  last_idx,
    output logic                      clear
);

    localparam int IW = $clog2(DEPTH);

    logic [7:0]  cap_reg;
    logic [7:0]  cap_next;
    logic        wr_en;
    logic [IW:0] eff_cap;

    // A write transfer completes in the access phase.
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_CAPACITY);
    assign clear  = wr_en;

    always_comb
    begin
        cap_next = cap_reg;
        if (wr_en)
        begin
            cap_next = pwdata[7:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= CAP_RESET;
        end
        else
        begin
            cap_reg <= cap_next;
        end
    end

    // Read data: the capacity register, zero elsewhere.
    always_comb
    begin
        if (paddr[2] == REG_CAPACITY)
        begin
            prdata = {{(APB_DW-8){1'b0}}, cap_reg};
        end
        else
        begin
            prdata = '0;
        end
    end

    // Clamp the capacity to the range one to DEPTH.
    always_comb
    begin
        if (cap_reg == 8'd0)
        begin
            eff_cap = (IW+1)'(1);
        end
        else if (32'(cap_reg) > 32'(DEPTH))
        begin
            eff_cap = (IW+1)'(DEPTH);
        end
        else
        begin
            eff_cap = (IW+1)'(cap_reg);
        end
    end

    assign last_idx = IW'(eff_cap - (IW+1)'(1));

endmodule

// File: hdl/cdq_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdq_mem
// Slot store of the deque: one write port and one read port with the read
// data registered, so a read returns its data in the cycle after its address.
// ----------------------------------------------------------------------------
module cdq_mem
#(
    parameter int DEPTH = 128
)
(
    input  logic                      clk,
    input  logic                      we,
    input  logic [$clog2(DEPTH)-1:0]  waddr,
    input  logic [31:0]               wdata,
    input  logic [$clog2(DEPTH)-1:0]  raddr,
    output logic [31:0]               rdata
);

    logic [31:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// File: hdl/cdq_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdq_ctrl
// Deque control: front and rear indices, the empty mark, cached front and
// rear values, store accesses and the registered result.
// ----------------------------------------------------------------------------
module cdq_ctrl
    import cdq_pkg::*;
#(
    parameter int DEPTH = 128
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [1:0]                op,
    input  logic signed [31:0]        data_in,
    input  logic [$clog2(DEPTH)-1:0]  last_idx,
    input  logic                      clear,
    output logic                      busy,
    output logic                      mem_we,
    output logic [$clog2(DEPTH)-1:0]  mem_waddr,
    output logic [31:0]               mem_wdata,
    output logic [$clog2(DEPTH)-1:0]  mem_raddr,
    input  logic [31:0]               mem_rdata,
    output logic                      done,
    output logic [1:0]                status,
    output logic signed [31:0]        front_value,
    output logic signed [31:0]        rear_value,
    output logic                      is_empty,
    output logic                      is_full
);

    localparam int IW = $clog2(DEPTH);

    op_t          op_c;
    logic         accept;
    logic         full;
    logic [IW:0]  rear_p1;
    logic [IW-1:0] front_inc;
    logic [IW-1:0] front_dec;
    logic [IW-1:0] rear_inc;
    logic [IW-1:0] rear_dec;

    logic [IW-1:0] front_reg, front_next;
    logic [IW-1:0] rear_reg, rear_next;
    logic          empty_reg, empty_next;
    logic [31:0]   fval_reg, fval_next;
    logic [31:0]   rval_reg, rval_next;
    logic          busy_reg, busy_next;
    stage_t        stage_reg, stage_next;
    logic          done_reg;
    logic [1:0]    status_reg;
    logic [31:0]   fout_reg, rout_reg;
    logic          eout_reg, full_out_reg;
    logic [31:0]   fval_cur, rval_cur;

    assign op_c   = op_t'(op);
    assign accept = start && !busy_reg;
    assign busy   = busy_reg;

    // Neighbor indices with wrap at the last slot in use.
    assign front_inc = (front_reg == last_idx) ? '0 : front_reg + IW'(1);
    assign front_dec = (front_reg == '0) ? last_idx : front_reg - IW'(1);
    assign rear_inc  = (rear_reg == last_idx) ? '0 : rear_reg + IW'(1);
    assign rear_dec  = (rear_reg == '0) ? last_idx : rear_reg - IW'(1);

    // Full when the front sits right after the rear.
    assign rear_p1 = {1'b0, rear_reg} + (IW+1)'(1);
    assign full    = !empty_reg &&
                     (((front_reg == '0) && (rear_reg == last_idx)) ||
                      ({1'b0, front_reg} == rear_p1));

    // Values after the pending store read lands.
    assign fval_cur = stage_reg.pend_front ? mem_rdata : fval_reg;
    assign rval_cur = stage_reg.pend_rear  ? mem_rdata : rval_reg;

    // Store read address: the new end after a delete.
    assign mem_raddr = (op_c == OP_DEL_FRONT) ? front_inc : rear_dec;
    assign mem_wdata = data_in;

    // Operation decode and state update.
    always_comb
    begin
        front_next = front_reg;
        rear_next  = rear_reg;
        empty_next = empty_reg;
        fval_next  = fval_cur;
        rval_next  = rval_cur;
        busy_next  = 1'b0;
        stage_next = stage_reg;
        // A pending store read lands in the busy cycle only.
        stage_next.pend_front = 1'b0;
        stage_next.pend_rear  = 1'b0;
        mem_we     = 1'b0;
        mem_waddr  = '0;
        if (clear)
        begin
            front_next = '0;
            rear_next  = '0;
            empty_next = 1'b1;
        end
        else if (accept)
        begin
            busy_next             = 1'b1;
            stage_next.status     = ST_DONE;
            stage_next.pend_front = 1'b0;
            stage_next.pend_rear  = 1'b0;
            case (op_c)
                OP_INS_FRONT, OP_INS_REAR:
                begin
                    if (full)
                    begin
                        stage_next.status = ST_FULL;
                    end
                    else if (empty_reg)
                    begin
                        front_next = '0;
                        rear_next  = '0;
                        empty_next = 1'b0;
                        mem_we     = 1'b1;
                        mem_waddr  = '0;
                        fval_next  = data_in;
                        rval_next  = data_in;
                    end
                    else if (op_c == OP_INS_FRONT)
                    begin
                        front_next = front_dec;
                        mem_we     = 1'b1;
                        mem_waddr  = front_dec;
                        fval_next  = data_in;
                    end
                    else
                    begin
                        rear_next = rear_inc;
                        mem_we    = 1'b1;
                        mem_waddr = rear_inc;
                        rval_next = data_in;
                    end
                end
                default:
                begin
                    if (empty_reg)
                    begin
                        stage_next.status = ST_EMPTY;
                    end
                    else if (front_reg == rear_reg)
                    begin
                        front_next = '0;
                        rear_next  = '0;
                        empty_next = 1'b1;
                    end
                    else if (op_c == OP_DEL_FRONT)
                    begin
                        front_next            = front_inc;
                        stage_next.pend_front = 1'b1;
                    end
                    else
                    begin
                        rear_next            = rear_dec;
                        stage_next.pend_rear = 1'b1;
                    end
                end
            endcase
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg <= '0;
            rear_reg  <= '0;
            empty_reg <= 1'b1;
            busy_reg  <= 1'b0;
            stage_reg <= '{status: ST_DONE, pend_front: 1'b0, pend_rear: 1'b0};
            done_reg  <= 1'b0;
        end
        else
        begin
            front_reg <= front_next;
            rear_reg  <= rear_next;
            empty_reg <= empty_next;
            busy_reg  <= busy_next;
            stage_reg <= stage_next;
            done_reg  <= busy_reg;
        end
    end

    // Cached end values and the result payload.
    always_ff @(posedge clk)
    begin
        fval_reg <= fval_next;
        rval_reg <= rval_next;
        if (busy_reg)
        begin
            status_reg   <= stage_reg.status;
            fout_reg     <= empty_reg ? '0 : fval_cur;
            rout_reg     <= empty_reg ? '0 : rval_cur;
            eout_reg     <= empty_reg;
            full_out_reg <= full;
        end
    end

    assign done        = done_reg;
    assign status      = status_reg;
    assign front_value = $signed(fout_reg);
    assign rear_value  = $signed(rout_reg);
    assign is_empty    = eout_reg;
    assign is_full     = full_out_reg;

endmodule

// File: hdl/circular_deque.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circular_deque
// Double-ended queue in a circular slot store with a configurable capacity.
// ----------------------------------------------------------------------------
// Each operation is accepted at a clock edge where start is high and busy is
// low; busy then stays high for one cycle while the slot store's registered
// read port fetches the new end value after a delete, and the result is shown
// for exactly one cycle, marked by done, which is the registered copy of busy.
// No new operation is accepted while busy is high.
// The result cannot be held off, so it must be captured while done is high.
// Writing the capacity register empties the deque; stored values stay, and
// no clearing pass runs after reset.
// ----------------------------------------------------------------------------
module circular_deque
    import cdq_pkg::*;
#(
    parameter int DEPTH = 128
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [1:0]          op,
    input  logic signed [31:0]  data_in,
    output logic                busy,
    output logic                done,
    output logic [1:0]          status,
    output logic signed [31:0]  front_value,
    output logic signed [31:0]  rear_value,
    output logic                is_empty,
    output logic                is_full,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [APB_DW-1:0]   pwdata,
    output logic [APB_DW-1:0]   prdata,
    output logic                pready
);

    localparam int IW = $clog2(DEPTH);

    logic [IW-1:0] last_idx;
    logic          clear;
    logic          mem_we;
    logic [IW-1:0] mem_waddr;
    logic [31:0]   mem_wdata;
    logic [IW-1:0] mem_raddr;
    logic [31:0]   mem_rdata;

    // Configuration registers.
    cdq_regs #(.DEPTH(DEPTH)) u_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .last_idx (last_idx),
        .clear    (clear)
    );

    // Slot store.
    cdq_mem #(.DEPTH(DEPTH)) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Deque control and result.
    cdq_ctrl #(.DEPTH(DEPTH)) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .op          (op),
        .data_in     (data_in),
        .last_idx    (last_idx),
        .clear       (clear),
        .busy        (busy),
        .mem_we      (mem_we),
        .mem_waddr   (mem_waddr),
        .mem_wdata   (mem_wdata),
        .mem_raddr   (mem_raddr),
        .mem_rdata   (mem_rdata),
        .done        (done),
        .status      (status),
        .front_value (front_value),
        .rear_value  (rear_value),
        .is_empty    (is_empty),
        .is_full     (is_full)
    );

endmodule

// File: hdl/cdq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdq_checker
// Port-level checks of the circular deque: transfer timing and consistency
// of the reported flags and values.
// ----------------------------------------------------------------------------
module cdq_checker
    import cdq_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                busy,
    input  logic                done,
    input  logic signed [31:0]  front_value,
    input  logic signed [31:0]  rear_value,
    input  logic                is_empty,
    input  logic                is_full
);

    // An accepted operation raises busy in the cycle after, blocking the next one.
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after an accepted operation");

    // Every accepted operation yields its result, marked by done, after busy.
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##2 done)
        else $error("result missing two cycles after acceptance");

    // Results never come in two consecutive cycles.
    assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held for more than one cycle");

    // An empty deque reports zero values and is never full.
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && is_empty) |-> (front_value == 0 && rear_value == 0 && !is_full))
        else $error("empty result with nonzero values or full flag");

endmodule

bind circular_deque cdq_checker u_cdq_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .done        (done),
    .front_value (front_value),
    .rear_value  (rear_value),
    .is_empty    (is_empty),
    .is_full     (is_full)
);

// File: verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circular_deque testbench
// Drives insert and delete operations at both ends of the deque and checks
// every result against a cycle-free model of the deque kept in a small
// scoreboard. The run starts with directed cases: empty and full refusals,
// index wrap, capacity 0, 1, 2 and values above 128, capacity writes that
// empty a filled deque, and a write to an unmapped register. Random phases
// follow, each with its own capacity, insert/delete mix and idle pattern.
// ----------------------------------------------------------------------------
module testbench;
    import cdq_pkg::*;

    localparam int SLOTS       = 128;
    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_OPS  = 1400;

    // Expected outcome of one deque operation.
    typedef struct {
        status_t     status;
        logic [31:0] front_value;
        logic [31:0] rear_value;
        logic        is_empty;
        logic        is_full;
    } deque_outcome_t;

    // Scoreboard: mirrors the deque contents and checks each result transfer.
    class deque_scoreboard;
        logic [31:0]    slots [SLOTS];
        int             front_idx;
        int             rear_idx;
        logic           empty;
        logic [7:0]     capacity_reg;
        deque_outcome_t pending_outcomes [$];
        int             failures;
        int             ops_checked;
        int             refused_full;
        int             refused_empty;
        int             capacity_writes;

        function new();
            capacity_reg    = CAP_RESET;
            front_idx       = 0;
            rear_idx        = 0;
            empty           = 1'b1;
            failures        = 0;
            ops_checked     = 0;
            refused_full    = 0;
            refused_empty   = 0;
            capacity_writes = 0;
            foreach (slots[i])
                slots[i] = '0;
        endfunction

        function int live_capacity();
            int c;
            c = capacity_reg;
            if (c < 1)
                c = 1;
            if (c > SLOTS)
                c = SLOTS;
            return c;
        endfunction

        function bit deque_is_full();
            int c;
            c = live_capacity();
            if (empty)
                return 1'b0;
            return (front_idx == 0 && rear_idx == c - 1) || (front_idx == rear_idx + 1);
        endfunction

        function int outstanding();
            return pending_outcomes.size();
        endfunction

        // A capacity write empties the deque; unmapped addresses are ignored.
        function void write_reg(logic [2:0] addr, logic [31:0] value);
            if (addr[2] != REG_CAPACITY)
                return;
            capacity_reg = value[7:0];
            front_idx    = 0;
            rear_idx     = 0;
            empty        = 1'b1;
            capacity_writes++;
        endfunction

        // Apply one accepted operation and queue the outcome it must produce.
        function void note_op(op_t code, logic [31:0] value);
            int             c;
            deque_outcome_t r;
            c = live_capacity();
            r.status = ST_DONE;
            if (code == OP_INS_FRONT || code == OP_INS_REAR)
            begin
                if (deque_is_full())
                    r.status = ST_FULL;
                else if (empty)
                begin
                    front_idx = 0;
                    rear_idx  = 0;
                    empty     = 1'b0;
                    slots[0]  = value;
                end
                else if (code == OP_INS_FRONT)
                begin
                    front_idx = (front_idx == 0) ? c - 1 : front_idx - 1;
                    slots[front_idx] = value;
                end
                else
                begin
                    rear_idx = (rear_idx == c - 1) ? 0 : rear_idx + 1;
                    slots[rear_idx] = value;
                end
            end
            else
            begin
                if (empty)
                    r.status = ST_EMPTY;
                else if (front_idx == rear_idx)
                begin
                    front_idx = 0;
                    rear_idx  = 0;
                    empty     = 1'b1;
                end
                else if (code == OP_DEL_FRONT)
                    front_idx = (front_idx == c - 1) ? 0 : front_idx + 1;
                else
                    rear_idx = (rear_idx == 0) ? c - 1 : rear_idx - 1;
            end
            r.front_value = empty ? 32'd0 : slots[front_idx];
            r.rear_value  = empty ? 32'd0 : slots[rear_idx];
            r.is_empty    = empty;
            r.is_full     = deque_is_full();
            pending_outcomes.push_back(r);
        endfunction

        // Compare one result transfer with the oldest queued outcome.
        function void check_result(logic [1:0] st, logic [31:0] fv, logic [31:0] rv,
                                   logic emp, logic ful);
            deque_outcome_t r;
            if (pending_outcomes.size() == 0)
            begin
                $error("result transfer with no operation outstanding");
                failures++;
                return;
            end
            r = pending_outcomes.pop_front();
            ops_checked++;
            if (r.status == ST_FULL)
                refused_full++;
            if (r.status == ST_EMPTY)
                refused_empty++;
            if (st !== r.status)
            begin
                $error("status: expected %0d, actual %0d", r.status, st);
                failures++;
            end
            if (fv !== r.front_value)
            begin
                $error("front_value: expected %h, actual %h", r.front_value, fv);
                failures++;
            end
            if (rv !== r.rear_value)
            begin
                $error("rear_value: expected %h, actual %h", r.rear_value, rv);
                failures++;
            end
            if (emp !== r.is_empty)
            begin
                $error("is_empty: expected %0d, actual %0d", r.is_empty, emp);
                failures++;
            end
            if (ful !== r.is_full)
            begin
                $error("is_full: expected %0d, actual %0d", r.is_full, ful);
                failures++;
            end
        endfunction
    endclass

    logic               clk     = 1'b0;
    logic               rst_n   = 1'b0;
    logic               start   = 1'b0;
    logic [1:0]         op      = 2'd0;
    logic signed [31:0] data_in = '0;
    logic               psel    = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite  = 1'b0;
    logic [2:0]         paddr   = 3'd0;
    logic [31:0]        pwdata  = '0;
    logic               busy;
    logic               done;
    logic [1:0]         status;
    logic signed [31:0] front_value;
    logic signed [31:0] rear_value;
    logic               is_empty;
    logic               is_full;
    logic [31:0]        prdata;
    logic               pready;

    deque_scoreboard sb = new();
    int  cycle_count = 0;
    bit  gaps_enabled = 1'b1;

    circular_deque #(.DEPTH(SLOTS)) uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .op          (op),
        .data_in     (data_in),
        .busy        (busy),
        .done        (done),
        .status      (status),
        .front_value (front_value),
        .rear_value  (rear_value),
        .is_empty    (is_empty),
        .is_full     (is_full),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always #5 clk = ~clk;

    // Observe transfers on the pre-edge values; results are checked before
    // a new operation is noted so the queue order always holds.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("circular_deque regression: fail");
            $finish;
        end
        else if (rst_n)
        begin
            if (done)
                sb.check_result(status, front_value, rear_value, is_empty, is_full);
            if (start && !busy)
                sb.note_op(op_t'(op), data_in);
            if (psel && penable && pwrite && pready)
                sb.write_reg(paddr, pwdata);
        end
    end

    function int draw_gap();
        return gaps_enabled ? $urandom_range(0, 14) : 0;
    endfunction

    // Present one operation after an idle gap and hold it until the transfer.
    task automatic issue_op(op_t code, logic [31:0] value);
        int gap;
        gap = draw_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start   <= 1'b1;
        op      <= code;
        data_in <= value;
        do
            @(posedge clk);
        while (busy);
    endtask

    // Stop issuing and wait until every outstanding result has arrived.
    task automatic drain();
        start <= 1'b0;
        do
            @(posedge clk);
        while (sb.outstanding() != 0);
    endtask

    // Register write over the configuration port, done while the block is idle.
    task automatic reg_write(logic [2:0] addr, logic [31:0] value);
        drain();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    function logic [31:0] draw_value();
        case ($urandom_range(0, 15))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'hFFFF_FFFF;
            3:       return 32'h0000_0000;
            default: return $urandom();
        endcase
    endfunction

    function logic [7:0] draw_capacity();
        case ($urandom_range(0, 9))
            0:       return 8'd0;
            1:       return 8'd1;
            2:       return 8'd2;
            3:       return 8'd128;
            4:       return 8'd255;
            5:       return 8'($urandom_range(129, 255));
            6:       return 8'($urandom_range(0, 255));
            default: return 8'($urandom_range(1, 8));
        endcase
    endfunction

    initial
    begin
        int phase;
        int phase_len;
        int insert_pct;
        int issued;
        op_t code;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Deletes on the empty deque after reset, then inserts at both ends
        // with the front index wrapping down from slot 0.
        issue_op(OP_DEL_FRONT, 32'h0000_0000);
        issue_op(OP_DEL_REAR,  32'hFFFF_FFFF);
        issue_op(OP_INS_FRONT, 32'h8000_0000);
        issue_op(OP_INS_FRONT, 32'h7FFF_FFFF);
        issue_op(OP_INS_REAR,  32'h0000_0000);
        issue_op(OP_INS_REAR,  32'hFFFF_FFFF);
        issue_op(OP_INS_FRONT, 32'h5555_5555);
        issue_op(OP_INS_REAR,  32'hAAAA_AAAA);
        repeat (3)
        begin
            issue_op(OP_DEL_FRONT, 32'hFFFF_FFFF);
            issue_op(OP_DEL_REAR,  32'h1234_5678);
        end
        issue_op(OP_DEL_REAR, 32'h0000_0000);

        // An unmapped register write must leave the held elements alone.
        issue_op(OP_INS_REAR, 32'h0000_1234);
        issue_op(OP_INS_REAR, 32'h0000_5678);
        reg_write(3'd4, 32'h0000_0001);
        issue_op(OP_DEL_FRONT, 32'h0000_0000);

        // Capacity 1 written over a filled deque: it starts empty again.
        reg_write(3'd0, 32'd1);
        issue_op(OP_DEL_FRONT, 32'h0000_0000);
        issue_op(OP_INS_REAR,  32'hDEAD_BEEF);
        issue_op(OP_INS_FRONT, 32'h0BAD_F00D);
        issue_op(OP_DEL_REAR,  32'h0000_0000);

        // Capacity 0 behaves as 1.
        reg_write(3'd0, 32'd0);
        issue_op(OP_INS_FRONT, 32'hCAFE_0001);
        issue_op(OP_INS_REAR,  32'hCAFE_0002);

        // Capacity 2: the front index wraps down, the rear index wraps both ways.
        reg_write(3'd0, 32'd2);
        issue_op(OP_INS_REAR,  32'h1111_1111);
        issue_op(OP_INS_FRONT, 32'h2222_2222);
        issue_op(OP_DEL_REAR,  32'h0000_0000);
        issue_op(OP_INS_REAR,  32'h3333_3333);

        // Values above 128 clamp to the full store; upper data bits are junk.
        reg_write(3'd0, {24'($urandom()), 8'd255});

        // Random phases, the first one filling a 128-slot deque to full.
        phase  = 0;
        issued = 0;
        while (issued < RANDOM_OPS)
        begin
            if (phase == 0)
            begin
                reg_write(3'd0, 32'd128);
                phase_len  = 250;
                insert_pct = 95;
            end
            else
            begin
                reg_write(3'd0, {24'd0, draw_capacity()});
                phase_len = $urandom_range(60, 180);
                case ($urandom_range(0, 3))
                    0:       insert_pct = 20;
                    1:       insert_pct = 50;
                    2:       insert_pct = 80;
                    default: insert_pct = 95;
                endcase
            end
            gaps_enabled = ($urandom_range(0, 2) != 0);
            for (int n = 0; n < phase_len; n++)
            begin
                if ($urandom_range(0, 99) < insert_pct)
                    code = $urandom_range(0, 1) ? OP_INS_REAR : OP_INS_FRONT;
                else
                    code = $urandom_range(0, 1) ? OP_DEL_REAR : OP_DEL_FRONT;
                issue_op(code, draw_value());
                // Now and then let the deque run dry of pending work mid-phase.
                if (n == phase_len / 2 && phase % 3 == 1)
                    drain();
            end
            issued += phase_len;
            phase++;
        end

        drain();
        repeat (4) @(posedge clk);

        $display("Checked %0d operations over %0d capacity writes and %0d random phases;",
                 sb.ops_checked, sb.capacity_writes, phase);
        $display("%0d inserts were refused as full and %0d deletes as empty.",
                 sb.refused_full, sb.refused_empty);
        if (sb.failures == 0)
            $display("circular_deque regression: pass");
        else
            $display("circular_deque regression: fail");
        $finish;
    end

endmodule
